>>> design/afl_pkg.sv
// afl_pkg: shared constants, operation and status codes, and the command
// structure that the top level broadcasts to every list cell.
// No dependencies.
package afl_pkg;

    localparam int MAX_ENTRIES = 32;
    localparam int IDX_W       = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);

    // Fixed field widths of the stream payload
    localparam int WORD_W   = 32;
    localparam int OP_W     = 3;
    localparam int POS_W    = 5;
    localparam int STAT_W   = 2;
    localparam int FOUND_W  = 5;
    localparam int ECNT_W   = 6;
    localparam int CAP_W    = 6;

    localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(32);

    typedef enum logic [OP_W-1:0] {
        OP_APPEND = 3'd0,
        OP_INSERT = 3'd1,
        OP_WRITE  = 3'd2,
        OP_READ   = 3'd3,
        OP_FIND   = 3'd4
    } afl_op_t;

    typedef enum logic [STAT_W-1:0] {
        ST_OK        = 2'd0,
        ST_OVERFLOW  = 2'd1,
        ST_RANGE     = 2'd2,
        ST_NOT_FOUND = 2'd3
    } afl_status_t;

    // Broadcast to all cells on an accepted beat
    typedef struct packed {
        logic                fire;
        logic [OP_W-1:0]     op;
        logic [POS_W-1:0]    pos;
        logic [CNT_W-1:0]    cnt;
        logic [WORD_W-1:0]   word;
    } afl_cmd_t;

endpackage

>>> design/fixed_capacity_array_list.sv
// fixed_capacity_array_list: ordered list of signed words in a row of cells.
// An accepted beat updates the cell row, then its result is registered in the output
// register; no new beat is taken until then. The result stage waits while the
// output register is held by a stalled sink.
// Reset (aresetn low, synchronous): count 0, capacity 32, no result pending;
// entry words are not cleared and are only read below the count.
module fixed_capacity_array_list
    import afl_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    // configuration: capacity_in_use
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [CAP_W-1:0]  cfg_data,
    // input stream
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [39:0]       s_tdata,   // [4:0] position, [36:5] word, rest zero
    input  logic [OP_W-1:0]   s_tuser,   // [2:0] op
    // result stream
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [47:0]       m_tdata    // [1:0] status, [33:2] read_word,
                                         // [38:34] found_at, [44:39] entry_count,
                                         // [45] is_empty, [46] is_full, [47] zero
);

    typedef enum logic [0:0] {
        S_IDLE,
        S_EXEC
    } state_t;

    state_t             state_reg, state_next;
    logic [CAP_W-1:0]   capacity_reg;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [OP_W-1:0]    op_reg;
    logic [POS_W-1:0]   pos_reg;
    logic [STAT_W-1:0]  status_reg;
    logic               m_valid_reg, m_valid_next;
    logic [47:0]        m_data_reg, m_data_next;

    logic               s_beat;
    logic [OP_W-1:0]    in_op;
    logic [POS_W-1:0]   in_pos;
    logic [WORD_W-1:0]  in_word;
    logic [CNT_W-1:0]   cap_eff;
    logic [CNT_W-1:0]   in_pos_c;
    logic [STAT_W-1:0]  in_status;
    logic               out_free;

    afl_cmd_t                cmd;
    logic [WORD_W-1:0]       cell_entry [MAX_ENTRIES];
    logic [MAX_ENTRIES-1:0]  match_vec;

    logic [STAT_W-1:0]  res_status;
    logic [WORD_W-1:0]  res_word;
    logic [FOUND_W-1:0] res_found;
    logic               res_full;

    function automatic logic cfg_is_zero(input logic [CAP_W-1:0] v);
        return (v == '0);
    endfunction

    // Take a config beat only with no item in the result stage; a config beat
    // wins over an input beat offered in the same cycle
    assign cfg_ready = (state_reg == S_IDLE);

    assign in_op   = s_tuser;
    assign in_pos  = s_tdata[POS_W-1:0];
    assign in_word = s_tdata[POS_W +: WORD_W];

    assign s_tready = (state_reg == S_IDLE) && !cfg_valid;
    assign s_beat   = s_tvalid && s_tready;

    // Clamp capacity: zero acts as one, large values saturate to the row size
    always_comb begin
        if (cfg_is_zero(capacity_reg)) begin
            cap_eff = CNT_W'(1);
        end else if (32'(capacity_reg) > 32'(MAX_ENTRIES)) begin
            cap_eff = CNT_W'(MAX_ENTRIES);
        end else begin
            cap_eff = CNT_W'(capacity_reg);
        end
    end

    assign in_pos_c = CNT_W'(in_pos);

    // Front-end checks: range first, then fullness
    always_comb begin
        in_status = ST_OK;
        unique case (in_op) inside
            OP_APPEND: begin
                if (count_reg >= cap_eff) in_status = ST_OVERFLOW;
            end
            OP_INSERT: begin
                if (in_pos_c > count_reg)       in_status = ST_RANGE;
                else if (count_reg >= cap_eff) in_status = ST_OVERFLOW;
            end
            OP_WRITE, OP_READ: begin
                if (in_pos_c >= count_reg) in_status = ST_RANGE;
            end
            default: begin
                in_status = ST_OK;
            end
        endcase
    end

    // Broadcast to the cell row; cells act only on a clean beat
    always_comb begin
        cmd.fire = s_beat && (in_status == ST_OK);
        cmd.op   = in_op;
        cmd.pos  = in_pos;
        cmd.cnt  = count_reg;
        cmd.word = in_word;
    end

    // Advance the count on a successful append or insert
    always_comb begin
        count_next = count_reg;
        if (cmd.fire && ((in_op == OP_APPEND) || (in_op == OP_INSERT))) begin
            count_next = count_reg + CNT_W'(1);
        end
    end

    genvar g;
    generate
        for (g = 0; g < MAX_ENTRIES; g++) begin : g_cell
            logic [WORD_W-1:0] prev_w;
            if (g == 0) begin : g_head
                assign prev_w = '0;
            end else begin : g_link
                assign prev_w = cell_entry[g-1];
            end
            afl_cell u_cell (
                .aclk       (aclk),
                .cell_idx   (IDX_W'(g)),
                .cmd        (cmd),
                .prev_entry (prev_w),
                .entry      (cell_entry[g]),
                .match      (match_vec[g])
            );
        end
    endgenerate

    // Result stage: read select and first-match encode on the updated row
    afl_pick u_pick (
        .entries    (cell_entry),
        .match_vec  (match_vec),
        .op         (op_reg),
        .pos        (pos_reg),
        .status_in  (status_reg),
        .status_out (res_status),
        .read_word  (res_word),
        .found_at   (res_found)
    );

    assign res_full = (count_reg >= cap_eff);
    assign out_free = !m_valid_reg || m_tready;

    always_comb begin
        state_next   = state_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end
        unique case (state_reg)
            S_IDLE: begin
                if (s_beat) state_next = S_EXEC;
            end
            S_EXEC: begin
                // hold the result stage until the output register frees up
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_data_next  = {1'b0,
                                    res_full,
                                    (count_reg == '0),
                                    ECNT_W'(count_reg),
                                    res_found,
                                    res_word,
                                    res_status};
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            capacity_reg <= CAP_RESET;
            count_reg    <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
            if (cfg_valid && cfg_ready) begin
                capacity_reg <= cfg_data;
            end
        end
    end

    // Payload: no reset needed
    always_ff @(posedge aclk) begin
        if (s_beat) begin
            op_reg     <= in_op;
            pos_reg    <= in_pos;
            status_reg <= in_status;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken while an item is still in flight");

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        32'(count_reg) <= 32'(MAX_ENTRIES))
        else $error("entry count beyond row size");

    a_count_moves_on_beat: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(aresetn) && (count_reg != $past(count_reg)) |->
            $past(s_tvalid && s_tready) && (count_reg == $past(count_reg) + CNT_W'(1)))
        else $error("count changed without an accepted append or insert");

    a_result_from_exec: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(aresetn) && $rose(m_tvalid) |-> $past(state_reg == S_EXEC))
        else $error("result beat raised outside the result stage");

endmodule

>>> design/afl_cell.sv
// afl_cell: one list entry. Holds its word, takes its lower neighbor's word
// on an insert shift, loads the new word, and flags a match for find.
// Depends on afl_pkg.
module afl_cell
    import afl_pkg::*;
(
    input  logic              aclk,
    input  logic [IDX_W-1:0]  cell_idx,
    input  afl_cmd_t          cmd,
    input  logic [WORD_W-1:0] prev_entry,
    output logic [WORD_W-1:0] entry,
    output logic              match
);

    logic [WORD_W-1:0] entry_reg, entry_next;
    logic              match_reg, match_next;
    logic [CNT_W-1:0]  idx_c, pos_c;
    logic              take_prev, load_word;

    assign idx_c = CNT_W'(cell_idx);
    assign pos_c = CNT_W'(cmd.pos);

    always_comb begin
        take_prev = 1'b0;
        load_word = 1'b0;
        unique case (cmd.op)
            OP_APPEND: begin
                load_word = (idx_c == cmd.cnt);
            end
            OP_INSERT: begin
                load_word = (idx_c == pos_c);
                take_prev = (idx_c > pos_c) && (idx_c <= cmd.cnt);
            end
            OP_WRITE: begin
                load_word = (idx_c == pos_c);
            end
            default: begin
                take_prev = 1'b0;
                load_word = 1'b0;
            end
        endcase

        entry_next = entry_reg;
        match_next = match_reg;
        if (cmd.fire) begin
            // compare against the word held before this beat's update
            match_next = (entry_reg == cmd.word) && (idx_c < cmd.cnt);
            if (take_prev) begin
                entry_next = prev_entry;
            end else if (load_word) begin
                entry_next = cmd.word;
            end
        end
    end

    always_ff @(posedge aclk) begin
        entry_reg <= entry_next;
        match_reg <= match_next;
    end

    assign entry = entry_reg;
    assign match = match_reg;

endmodule

>>> design/afl_pick.sv
// afl_pick: result stage logic. Selects the read word from the cell row and
// encodes the first matching cell for find.
// Depends on afl_pkg.
module afl_pick
    import afl_pkg::*;
(
    input  logic [WORD_W-1:0]      entries [MAX_ENTRIES],
    input  logic [MAX_ENTRIES-1:0] match_vec,
    input  logic [OP_W-1:0]        op,
    input  logic [POS_W-1:0]       pos,
    input  logic [STAT_W-1:0]      status_in,
    output logic [STAT_W-1:0]      status_out,
    output logic [WORD_W-1:0]      read_word,
    output logic [FOUND_W-1:0]     found_at
);

    logic [IDX_W-1:0] first_idx;
    logic             any_match;

    // lowest set match bit wins
    always_comb begin
        first_idx = '0;
        for (int i = MAX_ENTRIES - 1; i >= 0; i--) begin
            if (match_vec[i]) begin
                first_idx = IDX_W'(i);
            end
        end
        any_match = |match_vec;
    end

    always_comb begin
        status_out = status_in;
        read_word  = '0;
        found_at   = '0;
        unique case (op)
            OP_READ: begin
                if (status_in == ST_OK) begin
                    read_word = entries[IDX_W'(pos)];
                end
            end
            OP_FIND: begin
                if (any_match) begin
                    status_out = ST_OK;
                    found_at   = FOUND_W'(first_idx);
                end else begin
                    status_out = ST_NOT_FOUND;
                end
            end
            default: begin
                status_out = status_in;
            end
        endcase
    end

endmodule

>>> verif/fixed_capacity_array_list_checker.sv
// Passive checker for fixed_capacity_array_list: models the list, queues the result
// due for every accepted input beat and compares each result beat field by field.
// Depends on afl_pkg for the operation and status codes.
`timescale 1ns / 1ps

module fixed_capacity_array_list_checker
    import afl_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_valid,
    input  logic              cfg_ready,
    input  logic [CAP_W-1:0]  cfg_data,
    input  logic              s_tvalid,
    input  logic              s_tready,
    input  logic [39:0]       s_tdata,   // [4:0] position, [36:5] word, rest zero
    input  logic [OP_W-1:0]   s_tuser,   // [2:0] op
    input  logic              m_tvalid,
    input  logic              m_tready,
    input  logic [47:0]       m_tdata,   // [1:0] status, [33:2] read_word,
                                         // [38:34] found_at, [44:39] entry_count,
                                         // [45] is_empty, [46] is_full, [47] zero
    output int                mismatch_count,
    output int                results_pending
);

    typedef struct {
        afl_status_t         status;
        logic [WORD_W-1:0]   read_word;
        logic [FOUND_W-1:0]  found_at;
        logic [ECNT_W-1:0]   entry_count;
        logic                is_empty;
        logic                is_full;
    } list_result_t;

    logic [WORD_W-1:0] list_words [0:MAX_ENTRIES-1];
    int                list_count;
    logic [CAP_W-1:0]  capacity_reg;
    list_result_t      due_results [$];

    function automatic list_result_t apply_list_op(logic [OP_W-1:0] op, logic [POS_W-1:0] pos,
                                                   logic [WORD_W-1:0] word);
        list_result_t res;
        int           cap;
        int           n;
        bit           matched;
        cap = (capacity_reg == 0) ? 1 :
              (capacity_reg > MAX_ENTRIES) ? MAX_ENTRIES : int'(capacity_reg);
        res.status    = ST_OK;
        res.read_word = '0;
        res.found_at  = '0;
        matched       = 1'b0;
        case (op)
            OP_APPEND: begin
                if (list_count >= cap) begin
                    res.status = ST_OVERFLOW;
                end else begin
                    list_words[list_count] = word;
                    list_count++;
                end
            end
            OP_INSERT: begin
                // Position check wins over the full check
                if (int'(pos) > list_count) begin
                    res.status = ST_RANGE;
                end else if (list_count >= cap) begin
                    res.status = ST_OVERFLOW;
                end else begin
                    for (n = list_count; n > int'(pos); n--)
                        list_words[n] = list_words[n-1];
                    list_words[pos] = word;
                    list_count++;
                end
            end
            OP_WRITE: begin
                if (int'(pos) >= list_count)
                    res.status = ST_RANGE;
                else
                    list_words[pos] = word;
            end
            OP_READ: begin
                if (int'(pos) >= list_count)
                    res.status = ST_RANGE;
                else
                    res.read_word = list_words[pos];
            end
            OP_FIND: begin
                res.status = ST_NOT_FOUND;
                for (n = 0; n < list_count; n++) begin
                    if (!matched && list_words[n] == word) begin
                        matched      = 1'b1;
                        res.status   = ST_OK;
                        res.found_at = n[FOUND_W-1:0];
                    end
                end
            end
            default: ;
        endcase
        res.entry_count = list_count[ECNT_W-1:0];
        res.is_empty    = (list_count == 0);
        res.is_full     = (list_count >= cap);
        return res;
    endfunction

    task automatic check_field(string field, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            $error("%s mismatch: expected 0x%0h, actual 0x%0h", field, want, got);
            mismatch_count++;
        end
    endtask

    always @(posedge aclk) begin
        list_result_t want;
        if (!aresetn) begin
            list_count      = 0;
            capacity_reg    = CAP_RESET;
            mismatch_count  = 0;
            due_results.delete();
        end else begin
            if (cfg_valid && cfg_ready)
                capacity_reg = cfg_data;
            if (s_tvalid && s_tready)
                due_results.push_back(apply_list_op(s_tuser, s_tdata[4:0], s_tdata[36:5]));
            if (m_tvalid && m_tready) begin
                if (due_results.size() == 0) begin
                    $error("result beat 0x%0h arrived with no expectation pending", m_tdata);
                    mismatch_count++;
                end else begin
                    want = due_results.pop_front();
                    check_field("status", want.status, m_tdata[1:0]);
                    check_field("read_word", want.read_word, m_tdata[33:2]);
                    check_field("found_at", want.found_at, m_tdata[38:34]);
                    check_field("entry_count", want.entry_count, m_tdata[44:39]);
                    check_field("is_empty", want.is_empty, m_tdata[45]);
                    check_field("is_full", want.is_full, m_tdata[46]);
                    check_field("pad", 32'd0, m_tdata[47]);
                end
            end
        end
        results_pending = due_results.size();
    end

endmodule

>>> verif/fixed_capacity_array_list_test.sv
// Top of the fixed_capacity_array_list testbench: clock, reset, capacity writes,
// directed and random list operations with bursty sender and stalling sink.
// Depends on afl_pkg, the block and fixed_capacity_array_list_checker.
`timescale 1ns / 1ps

module fixed_capacity_array_list_test;
    import afl_pkg::*;

    localparam int CLK_HALF     = 10;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 8;
    localparam int PHASE_ITEMS  = 185;

    // Opcodes the block must treat as no-ops
    localparam logic [OP_W-1:0] OP_SPARE_LO  = 3'd5;
    localparam logic [OP_W-1:0] OP_SPARE_MID = 3'd6;
    localparam logic [OP_W-1:0] OP_SPARE_HI  = 3'd7;

    typedef enum {SINK_OPEN, SINK_BUSY, SINK_SLOW, SINK_HOLD} sink_mode_t;

    logic              aclk      = 1'b0;
    logic              aresetn   = 1'b0;
    logic              cfg_valid = 1'b0;
    logic              cfg_ready;
    logic [CAP_W-1:0]  cfg_data  = '0;
    logic              s_tvalid  = 1'b0;
    logic              s_tready;
    logic [39:0]       s_tdata   = '0;   // [4:0] position, [36:5] word, rest zero
    logic [OP_W-1:0]   s_tuser   = '0;   // [2:0] op
    logic              m_tvalid;
    logic              m_tready  = 1'b0;
    logic [47:0]       m_tdata;          // [1:0] status, [33:2] read_word,
                                         // [38:34] found_at, [44:39] entry_count,
                                         // [45] is_empty, [46] is_full, [47] zero
    int                mismatch_count;
    int                results_pending;
    int                cycle_count = 0;

    // Sender burst state and a pool of words already stored, for find hits
    int                burst_left = 0;
    logic [31:0]       word_pool [$];

    // Sink stall pattern
    sink_mode_t        sink_mode  = SINK_OPEN;
    int                sink_left  = 0;

    fixed_capacity_array_list DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    fixed_capacity_array_list_checker list_checker (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_data        (cfg_data),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .s_tuser         (s_tuser),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .mismatch_count  (mismatch_count),
        .results_pending (results_pending)
    );

    always begin
        #(CLK_HALF) aclk = 1'b1;
        #(CLK_HALF) aclk = 1'b0;
    end

    // Sink: switch between open, busy, slow and hold stretches; hold keeps ready low
    always @(negedge aclk) begin
        if (sink_left == 0) begin
            sink_mode = sink_mode_t'($urandom_range(0, 3));
            sink_left = (sink_mode == SINK_HOLD) ? $urandom_range(1, 20) : $urandom_range(8, 48);
        end
        sink_left--;
        case (sink_mode)
            SINK_OPEN: m_tready = 1'b1;
            SINK_BUSY: m_tready = ($urandom_range(0, 3) != 0);
            SINK_SLOW: m_tready = ($urandom_range(0, 3) == 0);
            default:   m_tready = 1'b0;
        endcase
    end

    // Watchdog: end the run if the block hangs
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("FAILURE");
        $finish;
    end

    // Hold off the sender until every outstanding result has drained
    task automatic drain_results();
        s_tvalid = 1'b0;
        while (results_pending != 0)
            @(negedge aclk);
    endtask

    // Write the capacity register while the list is idle
    task automatic write_capacity(logic [CAP_W-1:0] value);
        drain_results();
        cfg_valid = 1'b1;
        cfg_data  = value;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    // Drive one beat, wait for the handshake, then maybe close the burst
    task automatic send_op(logic [OP_W-1:0] op, logic [POS_W-1:0] pos, logic [31:0] word);
        s_tvalid = 1'b1;
        s_tuser  = op;
        s_tdata  = {3'b000, word, pos};
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
        if (op == OP_APPEND || op == OP_INSERT || op == OP_WRITE) begin
            word_pool.push_back(word);
            if (word_pool.size() > 64)
                void'(word_pool.pop_front());
        end
        burst_left--;
        if (burst_left <= 0) begin
            s_tvalid   = 1'b0;
            burst_left = $urandom_range(1, 24);
            // Occasionally let the pipeline run dry before the next burst
            if ($urandom_range(0, 39) == 0)
                drain_results();
            repeat ($urandom_range(1, 8)) @(negedge aclk);
        end
    endtask

    // One phase of random operations under a given capacity setting
    task automatic run_phase(logic [CAP_W-1:0] cap_setting, int items);
        int          eff_cap;
        int          pick;
        logic [2:0]  op;
        logic [4:0]  pos;
        logic [31:0] word;
        write_capacity(cap_setting);
        eff_cap = (cap_setting == 0) ? 1 :
                  (cap_setting > MAX_ENTRIES) ? MAX_ENTRIES : int'(cap_setting);
        repeat (items) begin
            pick = $urandom_range(0, 99);
            if (pick < 20)      op = OP_APPEND;
            else if (pick < 38) op = OP_INSERT;
            else if (pick < 56) op = OP_WRITE;
            else if (pick < 75) op = OP_READ;
            else if (pick < 96) op = OP_FIND;
            else                op = OP_W'($urandom_range(OP_SPARE_LO, OP_SPARE_HI));
            // Bias positions toward the live part of the list
            if ($urandom_range(0, 9) < 6)
                pos = POS_W'($urandom_range(0, (eff_cap > 31) ? 31 : eff_cap));
            else
                pos = POS_W'($urandom_range(0, 31));
            pick = $urandom_range(0, 99);
            if (pick < 40 && word_pool.size() != 0)
                word = word_pool[$urandom_range(0, word_pool.size() - 1)];
            else if (pick < 55)
                word = 32'($urandom_range(0, 7));
            else
                word = 32'($urandom);
            send_op(op, pos, word);
        end
    endtask

    initial begin
        burst_left = $urandom_range(1, 24);
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // Empty list at reset capacity: every access misses
        send_op(OP_READ,   5'd0,  32'h0000_0000);
        send_op(OP_FIND,   5'd0,  32'h0000_0000);
        send_op(OP_WRITE,  5'd0,  32'h1234_5678);
        send_op(OP_INSERT, 5'd1,  32'h1111_1111);
        send_op(OP_SPARE_LO, 5'd31, 32'hFFFF_FFFF);
        send_op(OP_SPARE_HI, 5'd0,  32'h0000_0000);

        // Capacity zero acts as one: fill, then overflow; position check comes first
        write_capacity(6'd0);
        send_op(OP_INSERT, 5'd2,  32'h2222_2222);
        send_op(OP_APPEND, 5'd0,  32'h8000_0000);
        send_op(OP_APPEND, 5'd0,  32'h3333_3333);
        send_op(OP_INSERT, 5'd0,  32'h4444_4444);
        send_op(OP_INSERT, 5'd2,  32'h4444_4444);
        send_op(OP_READ,   5'd0,  32'h0000_0000);

        // Capacity above the maximum saturates; insert at head, tail and middle
        write_capacity(6'd63);
        send_op(OP_INSERT, 5'd0,  32'h7FFF_FFFF);
        send_op(OP_INSERT, 5'd2,  32'hFFFF_FFFF);
        send_op(OP_INSERT, 5'd1,  32'h0000_0000);
        send_op(OP_WRITE,  5'd2,  32'h5A5A_5A5A);
        send_op(OP_WRITE,  5'd4,  32'hA5A5_A5A5);
        send_op(OP_READ,   5'd3,  32'h0000_0000);
        send_op(OP_READ,   5'd31, 32'h0000_0000);
        send_op(OP_FIND,   5'd31, 32'hFFFF_FFFF);
        send_op(OP_APPEND, 5'd0,  32'h0000_0000);
        send_op(OP_FIND,   5'd0,  32'h0000_0000);
        send_op(OP_SPARE_MID, 5'd17, 32'h0F0F_0F0F);

        // Capacity dropped below the count: entries stay, list reads as full
        write_capacity(6'd3);
        send_op(OP_APPEND, 5'd0,  32'h6666_6666);
        send_op(OP_READ,   5'd4,  32'h0000_0000);

        // Random phases, starting with small capacities so the list grows in steps
        run_phase(6'd8,  PHASE_ITEMS);
        run_phase(6'd14, PHASE_ITEMS);
        run_phase(6'd20, PHASE_ITEMS);
        run_phase(6'd1,  PHASE_ITEMS);
        run_phase(6'd27, PHASE_ITEMS);
        run_phase(6'd32, PHASE_ITEMS);
        run_phase(6'd63, PHASE_ITEMS);
        run_phase(6'd16, PHASE_ITEMS);
        run_phase(6'd0,  PHASE_ITEMS);
        run_phase(6'd45, PHASE_ITEMS);

        drain_results();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatch_count == 0 && results_pending == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

>>> sim.f
design/afl_pkg.sv
design/afl_cell.sv
design/afl_pick.sv
design/fixed_capacity_array_list.sv
verif/fixed_capacity_array_list_checker.sv
verif/fixed_capacity_array_list_test.sv
